/* rtl/slpa_pkg.sv */
package slpa_pkg;

    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_MAX_CENTERS = 1024;

    localparam int DIST_W  = 52;
    localparam int LABEL_W = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_COMPARE = 2'd1,
        REQ_READ    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 8'd3;

    // Write enables of the pixel store.
    typedef struct packed {
        logic dist_we;
        logic label_we;
    } t_wr_ctl;

endpackage

/* rtl/slic_pixel_assignment_top.sv */
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_req_type, pixel and center fields
// result    out        o_valid / i_ready          o_label, o_label_valid, o_updated, o_in_window
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A compare or read item passes through three distance stages (the store read
// runs beside the first), one compare and write-back, and one output load. An
// unknown request goes straight to the output load.
// A clear item sweeps the distance memory, one entry a cycle, over all
// MAX_WIDTH * MAX_HEIGHT entries, then loads its result. After reset the same
// sweep also clears labels, so no item is accepted until that sweep has
// covered all MAX_WIDTH * MAX_HEIGHT entries.
// A new item is accepted while the previous result waits in the output register;
// the block holds its finished result until the output register frees up.
module slic_pixel_assignment_top #(
    parameter int MAX_WIDTH   = slpa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = slpa_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CENTERS = slpa_pkg::DEF_MAX_CENTERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_pixel_x,
    input  logic [7:0]  i_pixel_y,
    input  logic [7:0]  i_pixel_ch0,
    input  logic [7:0]  i_pixel_ch1,
    input  logic [7:0]  i_pixel_ch2,
    input  logic [9:0]  i_center_id,
    input  logic [7:0]  i_center_x,
    input  logic [7:0]  i_center_y,
    input  logic [15:0] i_center_ch0,
    input  logic [15:0] i_center_ch1,
    input  logic [15:0] i_center_ch2,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_label,
    output logic        o_label_valid,
    output logic        o_updated,
    output logic        o_in_window,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [slpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [slpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import slpa_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_SWEEP, ST_IDLE, ST_CALC1, ST_CALC2, ST_CALC3, ST_CMP, ST_PUSH
    } t_state;

    t_state r_state;
    logic   r_sweep_labels;
    logic   r_sweep_result;
    logic [ADDR_W-1:0] r_sweep_addr;

    // Configuration registers.
    logic [8:0] r_width, r_height;
    logic [7:0] r_step, r_weight;

    // Captured item.
    t_req       r_req;
    logic [7:0] r_px, r_py, r_pc0, r_pc1, r_pc2, r_cx, r_cy;
    logic [9:0] r_cid;
    logic [15:0] r_cc0, r_cc1, r_cc2;
    logic        r_in_store;
    logic [ADDR_W-1:0] r_addr;

    // Pending result.
    logic [9:0] r_res_label;
    logic       r_res_lv, r_res_upd, r_res_inw;

    logic [DIST_W-1:0]  dist_new, rd_dist;
    logic [LABEL_W-1:0] rd_label;
    logic               rd_assigned;
    t_wr_ctl            wr;
    logic [ADDR_W-1:0]  waddr;
    logic [DIST_W-1:0]  wdist;
    logic               accept, in_store, in_win, take_upd, out_free;
    logic [ADDR_W-1:0]  addr_in;
    logic signed [11:0] sp, sc, s3;
    logic signed [11:0] tp, tc;
    logic               win_x, win_y;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free = !o_valid || i_ready;
    assign in_store = (32'(i_pixel_x) < MAX_WIDTH) && (32'(i_pixel_y) < MAX_HEIGHT);
    assign addr_in  = in_store
        ? ADDR_W'(32'(i_pixel_y) * MAX_WIDTH + 32'(i_pixel_x)) : '0;

    always_comb begin
        s3 = 12'(3 * 32'(r_step));
        sp = $signed({3'd0, r_px, 1'b0});
        sc = $signed({3'd0, r_cx, 1'b0});
        tp = $signed({3'd0, r_py, 1'b0});
        tc = $signed({3'd0, r_cy, 1'b0});
        win_x = (sp + 12'sd1 >= sc - s3) && (sp < sc + s3);
        win_y = (tp + 12'sd1 >= tc - s3) && (tp < tc + s3);
        in_win = r_in_store && ({1'b0, r_px} < r_width) && ({1'b0, r_py} < r_height)
                 && win_x && win_y;
        take_upd = (r_req == REQ_COMPARE) && in_win && (32'(r_cid) < MAX_CENTERS)
                   && (dist_new < rd_dist);
    end

    // Store write port: the sweep owns it in ST_SWEEP, compares in ST_CMP.
    always_comb begin
        wr    = '0;
        waddr = r_addr;
        wdist = dist_new;
        if (r_state == ST_SWEEP) begin
            wr.dist_we  = 1'b1;
            wr.label_we = r_sweep_labels;
            waddr = r_sweep_addr;
            wdist = DIST_MAX;
        end else if (r_state == ST_CMP && take_upd) begin
            wr.dist_we  = 1'b1;
            wr.label_we = 1'b1;
        end
    end

    slpa_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_waddr     (waddr),
        .i_wdist     (wdist),
        .i_wlabel    ((r_state == ST_SWEEP) ? LABEL_W'(0) : r_cid),
        .i_wassigned (r_state != ST_SWEEP),
        .i_re        (accept),
        .i_raddr     (addr_in),
        .o_rdist     (rd_dist),
        .o_rlabel    (rd_label),
        .o_rassigned (rd_assigned)
    );

    slpa_dist u_dist (
        .i_clk     (i_clk),
        .i_pix_ch0 (r_pc0),
        .i_pix_ch1 (r_pc1),
        .i_pix_ch2 (r_pc2),
        .i_cen_ch0 (r_cc0),
        .i_cen_ch1 (r_cc1),
        .i_cen_ch2 (r_cc2),
        .i_pix_x   (r_px),
        .i_pix_y   (r_py),
        .i_cen_x   (r_cx),
        .i_cen_y   (r_cy),
        .i_step    (r_step),
        .i_weight  (r_weight),
        .o_dist    (dist_new)
    );

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= t_req'(i_req_type);
            r_px <= i_pixel_x;     r_py <= i_pixel_y;
            r_pc0 <= i_pixel_ch0;  r_pc1 <= i_pixel_ch1;  r_pc2 <= i_pixel_ch2;
            r_cid <= i_center_id;
            r_cx <= i_center_x;    r_cy <= i_center_y;
            r_cc0 <= i_center_ch0; r_cc1 <= i_center_ch1; r_cc2 <= i_center_ch2;
            r_in_store <= in_store;
            r_addr <= addr_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_step   <= 8'd16;
            r_weight <= 8'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[8:0];
                CFG_HEIGHT: r_height <= i_cfg_data[8:0];
                CFG_STEP:   r_step   <= i_cfg_data[7:0];
                CFG_WEIGHT: r_weight <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Control state machine and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_SWEEP;
            r_sweep_labels <= 1'b1;
            r_sweep_result <= 1'b0;
            r_sweep_addr   <= '0;
            o_valid        <= 1'b0;
            o_label        <= '0;
            o_label_valid  <= 1'b0;
            o_updated      <= 1'b0;
            o_in_window    <= 1'b0;
        end else begin
            // In ST_PUSH the output register is reloaded below instead.
            if (o_valid && i_ready && r_state != ST_PUSH) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_SWEEP: begin
                    if (r_sweep_addr == LAST_ADDR) begin
                        r_sweep_addr <= '0;
                        r_state <= r_sweep_result ? ST_PUSH : ST_IDLE;
                    end else begin
                        r_sweep_addr <= r_sweep_addr + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_res_label <= '0;
                        r_res_lv    <= 1'b0;
                        r_res_upd   <= 1'b0;
                        r_res_inw   <= 1'b0;
                        case (t_req'(i_req_type))
                            REQ_CLEAR: begin
                                r_sweep_labels <= 1'b0;
                                r_sweep_result <= 1'b1;
                                r_state <= ST_SWEEP;
                            end
                            REQ_NONE: r_state <= ST_PUSH;
                            default:  r_state <= ST_CALC1;
                        endcase
                    end
                end
                ST_CALC1: r_state <= ST_CALC2;
                ST_CALC2: r_state <= ST_CALC3;
                ST_CALC3: r_state <= ST_CMP;
                ST_CMP: begin
                    r_res_upd <= take_upd;
                    r_res_inw <= (r_req == REQ_COMPARE) && in_win;
                    if (r_in_store) begin
                        r_res_label <= take_upd ? r_cid : rd_label;
                        r_res_lv    <= take_upd || rd_assigned;
                    end
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (out_free) begin
                        o_valid       <= 1'b1;
                        o_label       <= r_res_label;
                        o_label_valid <= r_res_lv;
                        o_updated     <= r_res_upd;
                        o_in_window   <= r_res_inw;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_update_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_updated || o_in_window))
        else $error("updated reported without in_window");

    a_write_only_sweep_or_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.dist_we |-> (r_state == ST_SWEEP || r_state == ST_CMP))
        else $error("store written outside sweep or compare");

    a_update_sets_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_updated) |-> o_label_valid)
        else $error("updated result without assigned label");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> !o_ready)
        else $error("item accepted during sweep");

endmodule

/* rtl/slpa_store.sv */
module slpa_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                        i_clk,
    input  slpa_pkg::t_wr_ctl           i_wr,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [slpa_pkg::DIST_W-1:0] i_wdist,
    input  logic [slpa_pkg::LABEL_W-1:0] i_wlabel,
    input  logic                        i_wassigned,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [slpa_pkg::DIST_W-1:0] o_rdist,
    output logic [slpa_pkg::LABEL_W-1:0] o_rlabel,
    output logic                        o_rassigned
);
    import slpa_pkg::*;

    // Distance memory and label memory share one address; a clear only writes
    // the distances.
    logic [DIST_W-1:0]  r_dist_mem [DEPTH];
    logic [LABEL_W:0]   r_lab_mem  [DEPTH];
    logic [LABEL_W:0]   r_lab_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.dist_we) begin
            r_dist_mem[i_waddr] <= i_wdist;
        end
        if (i_re) begin
            o_rdist <= r_dist_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.label_we) begin
            r_lab_mem[i_waddr] <= {i_wassigned, i_wlabel};
        end
        if (i_re) begin
            r_lab_q <= r_lab_mem[i_raddr];
        end
    end

    assign o_rlabel    = r_lab_q[LABEL_W-1:0];
    assign o_rassigned = r_lab_q[LABEL_W];

endmodule

/* rtl/slpa_dist.sv */
module slpa_dist (
    input  logic                        i_clk,
    input  logic [7:0]                  i_pix_ch0,
    input  logic [7:0]                  i_pix_ch1,
    input  logic [7:0]                  i_pix_ch2,
    input  logic [15:0]                 i_cen_ch0,
    input  logic [15:0]                 i_cen_ch1,
    input  logic [15:0]                 i_cen_ch2,
    input  logic [7:0]                  i_pix_x,
    input  logic [7:0]                  i_pix_y,
    input  logic [7:0]                  i_cen_x,
    input  logic [7:0]                  i_cen_y,
    input  logic [7:0]                  i_step,
    input  logic [7:0]                  i_weight,
    output logic [slpa_pkg::DIST_W-1:0] o_dist
);
    import slpa_pkg::*;

    logic signed [16:0] dc0, dc1, dc2;
    logic signed [8:0]  dx, dy;
    logic signed [33:0] p0, p1, p2;
    logic signed [17:0] px2, py2;

    logic [31:0] r_sq0, r_sq1, r_sq2;
    logic [16:0] r_ds2;
    logic [15:0] r_s2, r_w2;
    logic [33:0] dcsum;
    logic [49:0] r_a;
    logic [32:0] r_b;

    always_comb begin
        dc0 = $signed({1'b0, i_pix_ch0, 8'd0}) - $signed({1'b0, i_cen_ch0});
        dc1 = $signed({1'b0, i_pix_ch1, 8'd0}) - $signed({1'b0, i_cen_ch1});
        dc2 = $signed({1'b0, i_pix_ch2, 8'd0}) - $signed({1'b0, i_cen_ch2});
        dx  = $signed({1'b0, i_pix_x}) - $signed({1'b0, i_cen_x});
        dy  = $signed({1'b0, i_pix_y}) - $signed({1'b0, i_cen_y});
        p0  = dc0 * dc0;
        p1  = dc1 * dc1;
        p2  = dc2 * dc2;
        px2 = dx * dx;
        py2 = dy * dy;
        dcsum = {2'd0, r_sq0} + {2'd0, r_sq1} + {2'd0, r_sq2};
    end

    // Three stages: squares, weighted products, final sum.
    always_ff @(posedge i_clk) begin
        r_sq0 <= p0[31:0];
        r_sq1 <= p1[31:0];
        r_sq2 <= p2[31:0];
        r_ds2 <= {1'b0, px2[15:0]} + {1'b0, py2[15:0]};
        r_s2  <= i_step * i_step;
        r_w2  <= i_weight * i_weight;
        r_a   <= dcsum * r_s2;
        r_b   <= r_ds2 * r_w2;
        o_dist <= {2'd0, r_a} + {3'd0, r_b, 16'd0};
    end

endmodule
